[rtl/strict_priority_class_queues_top_defines.svh]
// ----------------------------------------------------------------------------
// Strict priority class queues: assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef STRICT_PRIORITY_CLASS_QUEUES_TOP_DEFINES_SVH
`define STRICT_PRIORITY_CLASS_QUEUES_TOP_DEFINES_SVH

// Generic property, disabled while reset is asserted.
`define SPQ_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A stalled transaction keeps its payload.
`define SPQ_ASSERT_HOLD(label, clk, rst_n, vld, rdy, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) else $error(msg);

`endif

[rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// Strict priority class queues: package
// Codes, payload types and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH_DEF = 256;
  localparam int HANDLE_BITS_DEF = 16;
  localparam int NUM_CLASSES     = 4;
  localparam int HANDLE_W        = 16;
  localparam int CNT_OUT_W       = 9;
  localparam int LIMIT_W         = 9;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  localparam logic [1:0] ACT_ENQ = 2'd0;
  localparam logic [1:0] ACT_DEQ = 2'd1;
  localparam logic [1:0] ACT_REL = 2'd2;

  localparam logic [1:0] CLS_REQ  = 2'd0;
  localparam logic [1:0] CLS_RESP = 2'd1;
  localparam logic [1:0] CLS_STAT = 2'd2;
  localparam logic [1:0] CLS_CONT = 2'd3;

  typedef struct packed {
    logic [1:0]          action;
    logic [1:0]          queue_class;
    logic                continued;
    logic [HANDLE_W-1:0] handle;
  } in_item_t;

  typedef struct packed {
    logic                 out_valid;
    logic [HANDLE_W-1:0]  out_handle;
    logic [1:0]           out_class;
    logic                 rejected;
    logic                 backpressure;
    logic [CNT_OUT_W-1:0] request_count;
    logic [CNT_OUT_W-1:0] response_count;
    logic [CNT_OUT_W-1:0] continued_count;
    logic                 idle;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic rd_capture;
  } ctrl_cmd_t;

  typedef struct packed {
    logic deq_hit;
  } dp_sts_t;

endpackage

[rtl/spq_if.sv]
// ----------------------------------------------------------------------------
// Strict priority class queues: channel interfaces
// Valid/ready channels for input transactions and results.
// ----------------------------------------------------------------------------
interface spq_in_if import spq_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/strict_priority_class_queues_top.sv]
// ----------------------------------------------------------------------------
// Strict priority class queues: top level
// Four class FIFOs in one shared RAM, strict priority dequeue, backpressure.
// ----------------------------------------------------------------------------
// Each input transaction yields exactly one result transaction. A dequeue
// that finds an item passes the read state, as the shared queue RAM has a
// registered read port; other actions register their result at the accept.
// A new transaction is taken when no read is pending and the result register
// is free or is being drained in the same cycle. The queue RAM needs no
// clearing after reset, so the block is ready as soon as reset is released.
// request_limit writes on cfg_we take effect at the next enqueue or dequeue.
module strict_priority_class_queues_top import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  spq_in_if.sink             in_chan,
  spq_out_if.source          out_chan,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_chan.data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;
  assign out_chan.data  = out_data;

endmodule

[rtl/spq_ram.sv]
// ----------------------------------------------------------------------------
// Strict priority class queues: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/spq_ctrl.sv]
// ----------------------------------------------------------------------------
// Strict priority class queues: controller
// Sequences accepts, the RAM read of a dequeue and the result handshake.
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    in_ready       = (state_r == S_IDLE) && (!out_valid_r || out_ready);
    cmd.accept     = in_valid && in_ready;
    cmd.rd_capture = (state_r == S_READ);
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept) begin
          if (sts.deq_hit) begin
            state_nxt = S_READ;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_READ: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/spq_datapath.sv]
// ----------------------------------------------------------------------------
// Strict priority class queues: datapath
// Queue pointers and counts, priority select, backpressure, result register.
// ----------------------------------------------------------------------------
module spq_datapath import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  in_item_t           in_data,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  input  ctrl_cmd_t          cmd,
  output dp_sts_t            sts,
  output out_item_t          out_data
);

  localparam int IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_W   = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int CMP_W     = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int ADDR_W    = IDX_W + 2;
  localparam int RAM_DEPTH = NUM_CLASSES << IDX_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  logic [IDX_W-1:0] head_r [NUM_CLASSES];
  logic [IDX_W-1:0] head_nxt [NUM_CLASSES];
  logic [IDX_W-1:0] tail_r [NUM_CLASSES];
  logic [IDX_W-1:0] tail_nxt [NUM_CLASSES];
  logic [CNT_W-1:0] cnt_r [NUM_CLASSES];
  logic [CNT_W-1:0] cnt_nxt [NUM_CLASSES];
  logic             shrink_r, shrink_nxt;
  logic [LIMIT_W-1:0] limit_r;
  out_item_t        result_r;

  logic [1:0]        enq_q, sel;
  logic              is_enq, is_deq, is_rel;
  logic              enq_full, enq_ok, deq_hit;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [STORE_W-1:0] ram_rdata;

  always_comb begin
    is_enq = (in_data.action == ACT_ENQ);
    is_deq = (in_data.action == ACT_DEQ);
    is_rel = (in_data.action == ACT_REL);
    enq_q  = in_data.continued ? CLS_CONT : in_data.queue_class;

    if (cnt_r[CLS_CONT] != '0) begin
      sel = CLS_CONT;
    end else if (cnt_r[CLS_STAT] != '0) begin
      sel = CLS_STAT;
    end else if (cnt_r[CLS_RESP] != '0) begin
      sel = CLS_RESP;
    end else begin
      sel = CLS_REQ;
    end

    deq_hit  = is_deq && (cnt_r[sel] != '0);
    enq_full = (cnt_r[enq_q] == FULL_CNT);
    enq_ok   = is_enq && !enq_full;

    for (int c = 0; c < NUM_CLASSES; c++) begin
      head_nxt[c] = head_r[c];
      tail_nxt[c] = tail_r[c];
      cnt_nxt[c]  = cnt_r[c];
      if (enq_ok && (enq_q == 2'(c))) begin
        tail_nxt[c] = (tail_r[c] == LAST_IDX) ? '0 : tail_r[c] + 1'b1;
        cnt_nxt[c]  = cnt_r[c] + 1'b1;
      end
      if (deq_hit && (sel == 2'(c))) begin
        head_nxt[c] = (head_r[c] == LAST_IDX) ? '0 : head_r[c] + 1'b1;
        cnt_nxt[c]  = cnt_r[c] - 1'b1;
      end
    end

    shrink_nxt = shrink_r;
    if (enq_ok) begin
      if (CMP_W'(cnt_nxt[CLS_REQ]) > CMP_W'(limit_r)) begin
        shrink_nxt = 1'b1;
      end
    end else if (deq_hit) begin
      if (CMP_W'(cnt_nxt[CLS_REQ]) <= CMP_W'(limit_r)) begin
        shrink_nxt = 1'b0;
      end
    end else if (is_rel) begin
      shrink_nxt = 1'b0;
    end

    ram_we    = cmd.accept && enq_ok;
    ram_waddr = {enq_q, tail_r[enq_q]};
    ram_re    = cmd.accept && deq_hit;
    ram_raddr = {sel, head_r[sel]};
  end

  spq_ram #(
    .WIDTH (STORE_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (STORE_W'(in_data.handle)),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_r[c] <= '0;
        tail_r[c] <= '0;
        cnt_r[c]  <= '0;
      end
      shrink_r <= 1'b0;
      limit_r  <= LIMIT_RESET;
    end else begin
      if (cmd.accept) begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
          head_r[c] <= head_nxt[c];
          tail_r[c] <= tail_nxt[c];
          cnt_r[c]  <= cnt_nxt[c];
        end
        shrink_r <= shrink_nxt;
      end
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      result_r.out_valid       <= deq_hit;
      result_r.out_handle      <= '0;
      result_r.out_class       <= deq_hit ? sel : CLS_REQ;
      result_r.rejected        <= is_enq && enq_full;
      result_r.backpressure    <= shrink_nxt;
      result_r.request_count   <= CNT_OUT_W'(cnt_nxt[CLS_REQ]);
      result_r.response_count  <= CNT_OUT_W'(cnt_nxt[CLS_RESP]);
      result_r.continued_count <= CNT_OUT_W'(cnt_nxt[CLS_CONT]);
      result_r.idle            <= (cnt_nxt[CLS_REQ] == '0) && (cnt_nxt[CLS_RESP] == '0) &&
                                  (cnt_nxt[CLS_STAT] == '0);
    end else if (cmd.rd_capture) begin
      result_r.out_handle <= HANDLE_W'(ram_rdata);
    end
  end

  assign sts.deq_hit = deq_hit;
  assign out_data    = result_r;

endmodule

[rtl/spq_checker.sv]
// ----------------------------------------------------------------------------
// Strict priority class queues: port checker
// Concurrent checks on the top level channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "strict_priority_class_queues_top_defines.svh"

module spq_checker import spq_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `SPQ_ASSERT_HOLD(a_out_hold, clk, rst_n, out_valid, out_ready, out_data, "result changed while stalled")

  `SPQ_ASSERT_RST(a_no_accept_on_stall, clk, rst_n, (out_valid && !out_ready) |-> !in_ready, "input taken while result stalled")

  `SPQ_ASSERT_RST(a_hit_not_rejected, clk, rst_n, (out_valid && out_data.out_valid) |-> !out_data.rejected, "dequeue result flagged rejected")

  `SPQ_ASSERT_RST(a_miss_zero, clk, rst_n, (out_valid && !out_data.out_valid) |-> (out_data.out_handle == '0 && out_data.out_class == CLS_REQ), "no-item result carries data")

  `SPQ_ASSERT_RST(a_idle_counts, clk, rst_n, (out_valid && out_data.idle) |-> (out_data.request_count == '0 && out_data.response_count == '0), "idle with waiting items")

endmodule

bind strict_priority_class_queues_top spq_checker u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Strict priority class queues: testbench
// Runs directed transactions, then randomized fill, drain and mixed phases
// under several request limits, with random gaps on both channels. Each
// result is checked per field against a table row or behavioral queue model.
// ----------------------------------------------------------------------------
module tb;
  import spq_pkg::*;

  localparam int          QDEPTH      = QUEUE_DEPTH_DEF;
  localparam int          ITEMS_TOTAL = 1900;
  localparam int          STALL_LIMIT = 2000;
  localparam logic [1:0]  ACT_UNUSED  = 2'd3;

  localparam out_item_t ALL_EMPTY = '{out_valid: 1'b0, out_handle: '0, out_class: CLS_REQ,
                                      rejected: 1'b0, backpressure: 1'b0, request_count: '0,
                                      response_count: '0, continued_count: '0, idle: 1'b1};
  localparam out_item_t ONE_REQUEST = '{out_valid: 1'b0, out_handle: '0, out_class: CLS_REQ,
                                        rejected: 1'b0, backpressure: 1'b0,
                                        request_count: 9'd1, response_count: '0,
                                        continued_count: '0, idle: 1'b0};

  typedef struct packed {
    logic [1:0]          act;
    logic [1:0]          cls;
    logic                cont;
    logic [HANDLE_W-1:0] hnd;
    logic                has_want;
    out_item_t           want;
  } dir_row_t;

  localparam int DIR_N = 20;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{ACT_DEQ,    CLS_REQ,  1'b0, 16'h0000, 1'b1, ALL_EMPTY},
    '{ACT_REL,    CLS_REQ,  1'b0, 16'h0000, 1'b1, ALL_EMPTY},
    '{ACT_UNUSED, CLS_CONT, 1'b1, 16'hFFFF, 1'b1, ALL_EMPTY},
    '{ACT_ENQ,    CLS_REQ,  1'b0, 16'hFFFF, 1'b1, ONE_REQUEST},
    '{ACT_ENQ,    CLS_RESP, 1'b0, 16'h0000, 1'b0, ALL_EMPTY},
    '{ACT_ENQ,    CLS_STAT, 1'b0, 16'h5A5A, 1'b0, ALL_EMPTY},
    '{ACT_ENQ,    CLS_REQ,  1'b1, 16'h8001, 1'b0, ALL_EMPTY},
    '{ACT_ENQ,    CLS_CONT, 1'b0, 16'h1234, 1'b0, ALL_EMPTY},
    '{ACT_ENQ,    CLS_STAT, 1'b1, 16'h7FFE, 1'b0, ALL_EMPTY},
    '{ACT_DEQ,    CLS_REQ,  1'b0, 16'h0000, 1'b0, ALL_EMPTY},
    '{ACT_ENQ,    CLS_RESP, 1'b1, 16'h0001, 1'b0, ALL_EMPTY},
    '{ACT_DEQ,    CLS_CONT, 1'b1, 16'hAAAA, 1'b0, ALL_EMPTY},
    '{ACT_DEQ,    CLS_STAT, 1'b0, 16'h5555, 1'b0, ALL_EMPTY},
    '{ACT_DEQ,    CLS_RESP, 1'b0, 16'h0000, 1'b0, ALL_EMPTY},
    '{ACT_DEQ,    CLS_REQ,  1'b0, 16'h0000, 1'b0, ALL_EMPTY},
    '{ACT_REL,    CLS_CONT, 1'b1, 16'hFFFF, 1'b0, ALL_EMPTY},
    '{ACT_DEQ,    CLS_REQ,  1'b0, 16'h0000, 1'b0, ALL_EMPTY},
    '{ACT_DEQ,    CLS_REQ,  1'b0, 16'h0000, 1'b0, ALL_EMPTY},
    '{ACT_DEQ,    CLS_REQ,  1'b0, 16'h0000, 1'b1, ALL_EMPTY},
    '{ACT_UNUSED, CLS_REQ,  1'b0, 16'h0000, 1'b1, ALL_EMPTY}
  };

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [LIMIT_W-1:0]  cfg_wdata;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  strict_priority_class_queues_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // queue model state
  logic [HANDLE_W-1:0] slot_mem [NUM_CLASSES][QDEPTH];
  int unsigned         rd_ptr   [NUM_CLASSES];
  int unsigned         wr_ptr   [NUM_CLASSES];
  int unsigned         fill_cnt [NUM_CLASSES];
  bit                  bp_flag;
  int unsigned         req_limit;

  out_item_t pending_status [$];

  int mismatches;
  int n_txn;
  int n_hits;
  int n_rejects;
  int n_bp;
  bit quiet;
  bit hold_off_req;

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic out_item_t predict_status(in_item_t t);
    out_item_t   s;
    int unsigned q;
    int          pick;
    s = '0;
    pick = -1;
    case (t.action)
      ACT_ENQ: begin
        q = t.continued ? CLS_CONT : t.queue_class;
        if (fill_cnt[q] >= QDEPTH) begin
          s.rejected = 1'b1;
          n_rejects++;
        end else begin
          slot_mem[q][wr_ptr[q]] = t.handle;
          wr_ptr[q] = (wr_ptr[q] + 1) % QDEPTH;
          fill_cnt[q]++;
          if (fill_cnt[CLS_REQ] > req_limit) bp_flag = 1'b1;
        end
      end
      ACT_DEQ: begin
        if (fill_cnt[CLS_CONT] != 0) pick = CLS_CONT;
        else if (fill_cnt[CLS_STAT] != 0) pick = CLS_STAT;
        else if (fill_cnt[CLS_RESP] != 0) pick = CLS_RESP;
        else if (fill_cnt[CLS_REQ] != 0) pick = CLS_REQ;
        if (pick >= 0) begin
          s.out_valid  = 1'b1;
          s.out_handle = slot_mem[pick][rd_ptr[pick]];
          s.out_class  = 2'(pick);
          rd_ptr[pick] = (rd_ptr[pick] + 1) % QDEPTH;
          fill_cnt[pick]--;
          n_hits++;
          if (bp_flag && fill_cnt[CLS_REQ] <= req_limit) bp_flag = 1'b0;
        end
      end
      ACT_REL: bp_flag = 1'b0;
      default: ;
    endcase
    s.backpressure    = bp_flag;
    s.request_count   = CNT_OUT_W'(fill_cnt[CLS_REQ]);
    s.response_count  = CNT_OUT_W'(fill_cnt[CLS_RESP]);
    s.continued_count = CNT_OUT_W'(fill_cnt[CLS_CONT]);
    s.idle = (fill_cnt[CLS_REQ] == 0 && fill_cnt[CLS_RESP] == 0 && fill_cnt[CLS_STAT] == 0);
    if (bp_flag) n_bp++;
    return s;
  endfunction

  task automatic send(in_item_t t, bit use_want = 1'b0, out_item_t want = '0);
    int unsigned gap;
    out_item_t   s;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    s = predict_status(t);
    pending_status.push_back(use_want ? want : s);
    n_txn++;
  endtask

  task automatic set_limit(int unsigned v);
    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[LIMIT_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    req_limit = v;
  endtask

  function automatic in_item_t rand_txn(logic [1:0] act);
    in_item_t t;
    t.action      = act;
    t.queue_class = 2'($urandom_range(0, 3));
    t.continued   = ($urandom_range(0, 4) == 0);
    t.handle      = 16'($urandom);
    return t;
  endfunction

  task automatic mix_phase(int n, int req_bias, int hold_at);
    in_item_t    t;
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) t = rand_txn(ACT_ENQ);
      else if (r < 85) t = rand_txn(ACT_DEQ);
      else if (r < 95) t = rand_txn(ACT_REL);
      else t = rand_txn(ACT_UNUSED);
      if ($urandom_range(0, 99) < req_bias) begin
        t.queue_class = CLS_REQ;
        t.continued   = 1'b0;
      end
      if (i == hold_at) hold_off_req = 1'b1;
      send(t);
    end
  endtask

  // fill one queue past full, then drain every queue
  task automatic fill_and_drain(logic [1:0] tgt, int extra);
    in_item_t    t;
    int unsigned r;
    int          over;
    over = 0;
    while (over < extra) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        t = rand_txn(ACT_REL);
      end else if (r < 6) begin
        t = rand_txn(ACT_UNUSED);
      end else begin
        t = rand_txn(ACT_ENQ);
        if (tgt == CLS_CONT && t.queue_class != CLS_CONT) begin
          t.continued = 1'b1;
        end else begin
          t.queue_class = tgt;
          t.continued   = 1'b0;
        end
        if (fill_cnt[tgt] == QDEPTH) over++;
      end
      send(t);
    end
    while (fill_cnt[0] + fill_cnt[1] + fill_cnt[2] + fill_cnt[3] != 0)
      send(rand_txn(($urandom_range(0, 19) == 0) ? ACT_REL : ACT_DEQ));
    repeat (2) send(rand_txn(ACT_DEQ));
  endtask

  task automatic cmp_field(string nm, logic [HANDLE_W-1:0] w, logic [HANDLE_W-1:0] g);
    if (g !== w) begin
      $display("%0t: %s expected %0h actual %0h", $time, nm, w, g);
      mismatches++;
    end
  endtask

  task automatic check_status(out_item_t got);
    out_item_t want;
    if (pending_status.size() == 0) begin
      $display("%0t: unexpected result %p", $time, got);
      mismatches++;
      return;
    end
    want = pending_status.pop_front();
    cmp_field("out_valid", want.out_valid, got.out_valid);
    cmp_field("out_handle", want.out_handle, got.out_handle);
    cmp_field("out_class", want.out_class, got.out_class);
    cmp_field("rejected", want.rejected, got.rejected);
    cmp_field("backpressure", want.backpressure, got.backpressure);
    cmp_field("request_count", want.request_count, got.request_count);
    cmp_field("response_count", want.response_count, got.response_count);
    cmp_field("continued_count", want.continued_count, got.continued_count);
    cmp_field("idle", want.idle, got.idle);
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    int unsigned g;
    out_ch.ready = 1'b0;
    stall_left = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_ch.valid === 1'b1 && out_ch.ready) check_status(out_ch.data);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = 80;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          stall_left = g - 1;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
      @(posedge clk);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb: no transaction for %0d cycles", STALL_LIMIT);
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    in_item_t t;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    mismatches   = 0;
    n_txn        = 0;
    n_hits       = 0;
    n_rejects    = 0;
    n_bp         = 0;
    quiet        = 1'b0;
    hold_off_req = 1'b0;
    bp_flag      = 1'b0;
    req_limit    = LIMIT_RESET;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      rd_ptr[c]   = 0;
      wr_ptr[c]   = 0;
      fill_cnt[c] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      t.action      = DIR_TAB[i].act;
      t.queue_class = DIR_TAB[i].cls;
      t.continued   = DIR_TAB[i].cont;
      t.handle      = DIR_TAB[i].hnd;
      send(t, DIR_TAB[i].has_want, DIR_TAB[i].want);
    end

    set_limit(0);
    mix_phase(150, 60, -1);
    set_limit($urandom_range(1, 12));
    mix_phase(250, 60, 100);
    set_limit(255);
    quiet = 1'b1;
    fill_and_drain(CLS_REQ, $urandom_range(2, 5));
    quiet = 1'b0;
    set_limit(LIMIT_RESET);
    fill_and_drain(2'($urandom_range(1, 3)), $urandom_range(2, 5));
    set_limit($urandom_range(0, 256));
    mix_phase(ITEMS_TOTAL - n_txn, 30, -1);

    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("tb: %0d transactions under 6 request limits, %0d handles dequeued,",
             n_txn, n_hits);
    $display("tb: %0d full-queue rejects, %0d results with backpressure set",
             n_rejects, n_bp);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_ram.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/strict_priority_class_queues_top.sv
rtl/spq_checker.sv
tb/tb.sv
